// ===== hw/rtl/button_debounce_long_press_assert.svh =====
// Assertion macros for the button debounce block.
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_ASSERT_SVH

`ifndef ASSERT_OFF

// Clocked check, held off while reset is high.
`define BDLP_ASSERT(lbl, clk, rst, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds through reset.
`define BDLP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define BDLP_ASSERT(lbl, clk, rst, prop, msg)
`define BDLP_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== hw/rtl/bdlp_pkg.sv =====
// Shared types and constants for the button debounce block.
`timescale 1ns / 1ps

package bdlp_pkg;

  localparam int PIN_W = 4;
  localparam int OUT_W = 4;
  localparam int CFG_W = 16;
  localparam int REG_IDX_W = 1;

  localparam logic [REG_IDX_W-1:0] REG_DEBOUNCE   = 1'd0;
  localparam logic [REG_IDX_W-1:0] REG_LONG_PRESS = 1'd1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RESET   = 16'd50;
  localparam logic [CFG_W-1:0] LONG_PRESS_RESET = 16'd1000;

  // What one lane reports for the current tick.
  typedef struct packed {
    logic stable;
    logic press;
    logic long_ev;
    logic long_held;
  } lane_res_t;

endpackage

// ===== hw/rtl/bdlp_lane.sv =====
// One button lane: settle and hold counters, debounced level, long-press flag.
`timescale 1ns / 1ps
`include "button_debounce_long_press_assert.svh"

module bdlp_lane #(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           advance,
  input  logic                           reading,
  input  logic [bdlp_pkg::CFG_W-1:0]     debounce_ticks,
  input  logic [bdlp_pkg::CFG_W-1:0]     long_press_ticks,
  output bdlp_pkg::lane_res_t            res
);

  localparam int CMP_W = (COUNT_WIDTH > bdlp_pkg::CFG_W) ? COUNT_WIDTH : bdlp_pkg::CFG_W;

  logic                   last_raw;
  logic [COUNT_WIDTH-1:0] settle_count;
  logic                   stable_level;
  logic [COUNT_WIDTH-1:0] hold_count;
  logic                   long_flag;
  logic                   holding;

  logic [COUNT_WIDTH-1:0] settle_count_next;
  logic                   stable_level_next;
  logic [COUNT_WIDTH-1:0] hold_count_next;
  logic                   long_flag_next;
  logic                   holding_next;
  logic                   press;
  logic                   long_ev;
  logic                   settled;

  always_comb begin
    if (reading != last_raw) begin
      settle_count_next = '0;
    end else if (settle_count == {COUNT_WIDTH{1'b1}}) begin
      settle_count_next = settle_count;
    end else begin
      settle_count_next = settle_count + 1'b1;
    end

    hold_count_next = hold_count;
    if (holding && (hold_count != {COUNT_WIDTH{1'b1}})) begin
      hold_count_next = hold_count + 1'b1;
    end

    stable_level_next = stable_level;
    long_flag_next    = long_flag;
    holding_next      = holding;
    press             = 1'b0;
    long_ev           = 1'b0;
    settled = CMP_W'(settle_count_next) > CMP_W'(debounce_ticks);

    if (settled) begin
      if (reading != stable_level) begin
        stable_level_next = reading;
        hold_count_next   = '0;
        holding_next      = reading;
        if (reading) begin
          press          = 1'b1;
          long_flag_next = 1'b0;
        end
      end
      // Flag the long press once the hold reaches the setting.
      if (stable_level_next && !long_flag_next && holding_next &&
          (CMP_W'(hold_count_next) >= CMP_W'(long_press_ticks))) begin
        long_flag_next = 1'b1;
        long_ev        = 1'b1;
      end
    end

    res.stable    = stable_level_next;
    res.press     = press;
    res.long_ev   = long_ev;
    res.long_held = long_flag_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      last_raw     <= 1'b0;
      settle_count <= '0;
      stable_level <= 1'b0;
      hold_count   <= '0;
      long_flag    <= 1'b0;
      holding      <= 1'b0;
    end else if (advance) begin
      last_raw     <= reading;
      settle_count <= settle_count_next;
      stable_level <= stable_level_next;
      hold_count   <= hold_count_next;
      long_flag    <= long_flag_next;
      holding      <= holding_next;
    end
  end

  `BDLP_ASSERT(a_raw_change_restarts, clk, rst, (advance && (reading != last_raw)) |=> (settle_count == '0), "settle count not restarted on raw change")
  `BDLP_ASSERT(a_press_starts_hold, clk, rst, (advance && res.press) |=> (holding && stable_level && (hold_count == '0)), "press did not start hold timing")
  `BDLP_ASSERT(a_long_ev_sets_flag, clk, rst, (advance && res.long_ev) |=> (long_flag && holding), "long press event without flag")

endmodule

// ===== hw/rtl/bdlp_merge.sv =====
// Merge stage: gathers lane results into the output fields and holds the result.
`timescale 1ns / 1ps
`include "button_debounce_long_press_assert.svh"

module bdlp_merge #(
  parameter int BUTTONS = 4
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  bdlp_pkg::lane_res_t             res [BUTTONS],
  input  logic                            out_stall,
  output logic                            out_valid,
  output logic [bdlp_pkg::OUT_W-1:0]      stable_pressed,
  output logic [bdlp_pkg::OUT_W-1:0]      press_events,
  output logic [bdlp_pkg::OUT_W-1:0]      long_press_events,
  output logic [bdlp_pkg::OUT_W-1:0]      long_held,
  output logic                            any_pressed
);

  logic [bdlp_pkg::OUT_W-1:0] stable_vec;
  logic [bdlp_pkg::OUT_W-1:0] press_vec;
  logic [bdlp_pkg::OUT_W-1:0] long_ev_vec;
  logic [bdlp_pkg::OUT_W-1:0] long_vec;
  logic                       any_next;

  // Lanes beyond the field width still count towards any_pressed.
  for (genvar i = 0; i < bdlp_pkg::OUT_W; i++) begin : g_bit
    if (i < BUTTONS) begin : g_lane
      assign stable_vec[i]  = res[i].stable;
      assign press_vec[i]   = res[i].press;
      assign long_ev_vec[i] = res[i].long_ev;
      assign long_vec[i]    = res[i].long_held;
    end else begin : g_none
      assign stable_vec[i]  = 1'b0;
      assign press_vec[i]   = 1'b0;
      assign long_ev_vec[i] = 1'b0;
      assign long_vec[i]    = 1'b0;
    end
  end

  always_comb begin
    any_next = 1'b0;
    for (int i = 0; i < BUTTONS; i++) begin
      any_next = any_next | res[i].stable;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      stable_pressed    <= stable_vec;
      press_events      <= press_vec;
      long_press_events <= long_ev_vec;
      long_held         <= long_vec;
      any_pressed       <= any_next;
    end
  end

  `BDLP_ASSERT(a_load_gives_valid, clk, rst, load |=> out_valid, "loaded result not shown")
  `BDLP_ASSERT_ALWAYS(a_reset_clears_valid, clk, rst |=> !out_valid, "result valid straight after reset")
  `BDLP_ASSERT(a_stall_holds_result, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable({stable_pressed, press_events, long_press_events, long_held, any_pressed})), "stalled result changed")

endmodule

// ===== hw/rtl/button_debounce_long_press.sv =====
// Top level: four-button debouncer with long-press detection.
//
//   channel   signals                          direction
//   input     in_valid, in_stall, pin_levels   tick in, one per item
//   output    out_valid, out_stall, fields     one result per tick
//   config    cfg_we, cfg_index, cfg_data      register writes
//
// One tick is taken per clock while in_stall is low; its result appears in the output register
// on the next cycle. All lanes update in parallel in the accepting cycle.
// in_stall rises only while a held result is stalled; a result taken in the
// same cycle frees the register for the next tick.
// Reset (synchronous) clears every lane to not pressed and restores the
// register defaults of 50 and 1000 ticks.
`timescale 1ns / 1ps

module button_debounce_long_press #(
  parameter int BUTTONS     = 4,
  parameter int COUNT_WIDTH = 16
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic [bdlp_pkg::PIN_W-1:0]         pin_levels,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic [bdlp_pkg::OUT_W-1:0]         stable_pressed,
  output logic [bdlp_pkg::OUT_W-1:0]         press_events,
  output logic [bdlp_pkg::OUT_W-1:0]         long_press_events,
  output logic [bdlp_pkg::OUT_W-1:0]         long_held,
  output logic                               any_pressed,
  input  logic                               cfg_we,
  input  logic [bdlp_pkg::REG_IDX_W-1:0]     cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]         cfg_data
);

  logic [bdlp_pkg::CFG_W-1:0] debounce_ticks;
  logic [bdlp_pkg::CFG_W-1:0] long_press_ticks;
  logic                       accept;
  bdlp_pkg::lane_res_t        lane_res [BUTTONS];

  assign in_stall = out_valid && out_stall;
  assign accept   = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      debounce_ticks   <= bdlp_pkg::DEBOUNCE_RESET;
      long_press_ticks <= bdlp_pkg::LONG_PRESS_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        bdlp_pkg::REG_DEBOUNCE:   debounce_ticks   <= cfg_data;
        bdlp_pkg::REG_LONG_PRESS: long_press_ticks <= cfg_data;
        default: ;
      endcase
    end
  end

  for (genvar i = 0; i < BUTTONS; i++) begin : g_lane
    logic reading;
    // Buttons past the pin field read as pressed.
    if (i < bdlp_pkg::PIN_W) begin : g_pin
      assign reading = ~pin_levels[i];
    end else begin : g_nopin
      assign reading = 1'b1;
    end

    bdlp_lane #(
      .COUNT_WIDTH(COUNT_WIDTH)
    ) u_lane (
      .clk              (clk),
      .rst              (rst),
      .advance          (accept),
      .reading          (reading),
      .debounce_ticks   (debounce_ticks),
      .long_press_ticks (long_press_ticks),
      .res              (lane_res[i])
    );
  end

  bdlp_merge #(
    .BUTTONS(BUTTONS)
  ) u_merge (
    .clk               (clk),
    .rst               (rst),
    .load              (accept),
    .res               (lane_res),
    .out_stall         (out_stall),
    .out_valid         (out_valid),
    .stable_pressed    (stable_pressed),
    .press_events      (press_events),
    .long_press_events (long_press_events),
    .long_held         (long_held),
    .any_pressed       (any_pressed)
  );

endmodule

// ===== sim/button_debounce_long_press_checker.sv =====
// Checker for the button debouncer: predicts every tick's result and compares it on the output.
`timescale 1ns / 1ps

module button_debounce_long_press_checker (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  input  logic                          in_stall,
  input  logic [bdlp_pkg::PIN_W-1:0]    pin_levels,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [bdlp_pkg::OUT_W-1:0]    stable_pressed,
  input  logic [bdlp_pkg::OUT_W-1:0]    press_events,
  input  logic [bdlp_pkg::OUT_W-1:0]    long_press_events,
  input  logic [bdlp_pkg::OUT_W-1:0]    long_held,
  input  logic                          any_pressed,
  input  logic                          cfg_we,
  input  logic [bdlp_pkg::REG_IDX_W-1:0] cfg_index,
  input  logic [bdlp_pkg::CFG_W-1:0]    cfg_data,
  output int                            errors,
  output int                            pending,
  output int                            checked
);

  localparam int NUM_BUTTONS = 4;
  localparam logic [bdlp_pkg::CFG_W-1:0] COUNT_TOP = '1;

  typedef struct packed {
    logic [bdlp_pkg::OUT_W-1:0] stable;
    logic [bdlp_pkg::OUT_W-1:0] press;
    logic [bdlp_pkg::OUT_W-1:0] long_ev;
    logic [bdlp_pkg::OUT_W-1:0] long_held;
    logic                       any;
  } tick_result_t;

  logic [bdlp_pkg::CFG_W-1:0] debounce_set;
  logic [bdlp_pkg::CFG_W-1:0] long_set;
  logic [NUM_BUTTONS-1:0]     raw_prev;
  logic [NUM_BUTTONS-1:0]     level;
  logic [NUM_BUTTONS-1:0]     long_latched;
  logic [NUM_BUTTONS-1:0]     timing;
  logic [bdlp_pkg::CFG_W-1:0] settle_cnt [NUM_BUTTONS];
  logic [bdlp_pkg::CFG_W-1:0] hold_cnt [NUM_BUTTONS];
  tick_result_t               expected_ticks [$];
  int                         shown = 0;

  function automatic logic [bdlp_pkg::CFG_W-1:0] bump(input logic [bdlp_pkg::CFG_W-1:0] c);
    return (c == COUNT_TOP) ? c : c + 1'b1;
  endfunction

  task automatic advance_buttons(input logic [bdlp_pkg::PIN_W-1:0] pins,
                                 output tick_result_t r);
    logic pressed;
    r = '0;
    for (int b = 0; b < NUM_BUTTONS; b++) begin
      pressed = ~pins[b];
      settle_cnt[b] = (pressed != raw_prev[b]) ? '0 : bump(settle_cnt[b]);
      // hold time runs on every tick, settled or not
      if (timing[b]) hold_cnt[b] = bump(hold_cnt[b]);
      if (settle_cnt[b] > debounce_set) begin
        if (pressed != level[b]) begin
          level[b]    = pressed;
          timing[b]   = pressed;
          hold_cnt[b] = '0;
          if (pressed) begin
            r.press[b]      = 1'b1;
            long_latched[b] = 1'b0;
          end
        end
        if (level[b] && !long_latched[b] && timing[b] && hold_cnt[b] >= long_set) begin
          long_latched[b] = 1'b1;
          r.long_ev[b]    = 1'b1;
        end
      end
      raw_prev[b] = pressed;
    end
    r.stable    = level;
    r.long_held = long_latched;
    r.any       = |level;
  endtask

  task automatic report_mismatch(input string what, input logic [bdlp_pkg::OUT_W-1:0] want,
                                 input logic [bdlp_pkg::OUT_W-1:0] got);
    errors++;
    if (shown < 30) $display("mismatch, %s: expected %h, got %h", what, want, got);
    shown++;
  endtask

  always @(posedge clk) begin
    tick_result_t want;
    tick_result_t got;
    if (rst) begin
      debounce_set = bdlp_pkg::DEBOUNCE_RESET;
      long_set     = bdlp_pkg::LONG_PRESS_RESET;
      raw_prev     = '0;
      level        = '0;
      long_latched = '0;
      timing       = '0;
      for (int b = 0; b < NUM_BUTTONS; b++) begin
        settle_cnt[b] = '0;
        hold_cnt[b]   = '0;
      end
      expected_ticks.delete();
    end else begin
      // take the result first: it always belongs to an earlier tick
      if (out_valid && !out_stall) begin
        got = {stable_pressed, press_events, long_press_events, long_held, any_pressed};
        if (expected_ticks.size() == 0) begin
          report_mismatch("result with no tick outstanding", '0, got.stable);
        end else begin
          want = expected_ticks.pop_front();
          checked++;
          if (got.stable != want.stable) report_mismatch("stable_pressed", want.stable, got.stable);
          if (got.press != want.press) report_mismatch("press_events", want.press, got.press);
          if (got.long_ev != want.long_ev)
            report_mismatch("long_press_events", want.long_ev, got.long_ev);
          if (got.long_held != want.long_held)
            report_mismatch("long_held", want.long_held, got.long_held);
          if (got.any != want.any) report_mismatch("any_pressed", want.any, got.any);
        end
      end
      if (cfg_we) begin
        case (cfg_index)
          bdlp_pkg::REG_DEBOUNCE: begin
            debounce_set = cfg_data;
          end
          bdlp_pkg::REG_LONG_PRESS: begin
            long_set = cfg_data;
          end
          default: begin
          end
        endcase
      end
      if (in_valid && !in_stall) begin
        advance_buttons(pin_levels, want);
        expected_ticks.push_back(want);
      end
    end
    pending <= expected_ticks.size();
  end

endmodule

// ===== sim/button_debounce_long_press_tb.sv =====
// Testbench top for the button debouncer: stimulus, register settings and verdict.
`timescale 1ns / 1ps

module button_debounce_long_press_tb;

  localparam int CYCLE_LIMIT      = 100_000;
  localparam int RANDOM_PER_PHASE = 155;
  localparam int RANDOM_PHASES    = 6;

  logic                           clk;
  logic                           rst        = 1'b1;
  logic                           in_valid   = 1'b0;
  logic                           out_stall  = 1'b0;
  logic                           cfg_we     = 1'b0;
  logic [bdlp_pkg::PIN_W-1:0]     pin_levels = '1;
  logic [bdlp_pkg::REG_IDX_W-1:0] cfg_index  = bdlp_pkg::REG_DEBOUNCE;
  logic [bdlp_pkg::CFG_W-1:0]     cfg_data   = '0;

  logic                           in_stall;
  logic                           out_valid;
  logic [bdlp_pkg::OUT_W-1:0]     stable_pressed;
  logic [bdlp_pkg::OUT_W-1:0]     press_events;
  logic [bdlp_pkg::OUT_W-1:0]     long_press_events;
  logic [bdlp_pkg::OUT_W-1:0]     long_held;
  logic                           any_pressed;

  int errors;
  int pending;
  int checked;
  int cycles     = 0;
  int ticks_sent = 0;
  int settings   = 0;
  int src_idle   = 0;
  int dst_idle   = 0;

  // per-button intended level and remaining contact bounce
  logic [bdlp_pkg::PIN_W-1:0] intent = '1;
  int                         bounce_left [bdlp_pkg::PIN_W];

  button_debounce_long_press i_dut (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .pin_levels        (pin_levels),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .stable_pressed    (stable_pressed),
    .press_events      (press_events),
    .long_press_events (long_press_events),
    .long_held         (long_held),
    .any_pressed       (any_pressed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data)
  );

  button_debounce_long_press_checker i_chk (
    .clk               (clk),
    .rst               (rst),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .pin_levels        (pin_levels),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .stable_pressed    (stable_pressed),
    .press_events      (press_events),
    .long_press_events (long_press_events),
    .long_held         (long_held),
    .any_pressed       (any_pressed),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .errors            (errors),
    .pending           (pending),
    .checked           (checked)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < dst_idle);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  task automatic send_tick(input logic [bdlp_pkg::PIN_W-1:0] lv);
    while ($urandom_range(0, 99) < src_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    pin_levels <= lv;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  // Drain, let the output register settle, then write both registers.
  task automatic write_regs(input logic [bdlp_pkg::CFG_W-1:0] deb,
                            input logic [bdlp_pkg::CFG_W-1:0] lp);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (3) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= bdlp_pkg::REG_DEBOUNCE;
    cfg_data  <= deb;
    @(posedge clk);
    cfg_index <= bdlp_pkg::REG_LONG_PRESS;
    cfg_data  <= lp;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings++;
  endtask

  // Mostly clean presses and releases with bounce; some ticks are pure noise.
  task automatic shape_pins(input int deb, output logic [bdlp_pkg::PIN_W-1:0] lv);
    if ($urandom_range(0, 99) < 8) begin
      lv = bdlp_pkg::PIN_W'($urandom_range(0, 15));
    end else begin
      for (int b = 0; b < bdlp_pkg::PIN_W; b++) begin
        if (bounce_left[b] > 0) begin
          lv[b] = 1'($urandom_range(0, 1));
          bounce_left[b]--;
        end else begin
          if ($urandom_range(0, 99) < 4) begin
            intent[b]      = ~intent[b];
            bounce_left[b] = $urandom_range(0, deb + 3);
          end
          lv[b] = intent[b];
        end
      end
    end
  endtask

  initial begin
    logic [bdlp_pkg::CFG_W-1:0] deb;
    logic [bdlp_pkg::CFG_W-1:0] lp;
    logic [bdlp_pkg::PIN_W-1:0] lv;
    for (int b = 0; b < bdlp_pkg::PIN_W; b++) bounce_left[b] = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    src_idle = 12;
    dst_idle = 65;
    // debounce and long-press settings of zero, long press flagged on the press tick itself
    write_regs('0, '0);
    repeat (3) send_tick(4'b0000);
    repeat (3) send_tick(4'b1111);
    send_tick(4'b0101);
    send_tick(4'b1010);
    send_tick(4'b0101);
    send_tick(4'b0110);
    send_tick(4'b1001);
    // shortest non-zero hold, then release keeps the long flag
    write_regs(16'd1, 16'd1);
    repeat (4) send_tick(4'b1110);
    repeat (3) send_tick(4'b1111);
    // top debounce value: no level change is ever accepted
    write_regs('1, '1);
    repeat (3) send_tick(4'b0000);

    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      src_idle = (ph < 2) ? 12 : (ph < 4) ? 65 : 0;
      dst_idle = (ph < 2) ? 65 : (ph < 4) ? 12 : 0;
      case (ph)
        0: begin deb = 16'd0; lp = 16'd1;  end
        1: begin deb = 16'd2; lp = 16'd8;  end
        2: begin deb = 16'd1; lp = 16'd0;  end
        3: begin deb = 16'd4; lp = 16'd25; end
        4: begin
          deb = bdlp_pkg::CFG_W'($urandom_range(0, 6));
          lp  = bdlp_pkg::CFG_W'($urandom_range(1, 40));
        end
        default: begin deb = 16'd3; lp = 16'd12; end
      endcase
      write_regs(deb, lp);
      repeat (RANDOM_PER_PHASE) begin
        shape_pins(deb, lv);
        send_tick(lv);
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d ticks over %0d register settings, incl. bounce, noise and edge settings",
             ticks_sent, settings);
    $display("%0d results compared, %0d mismatches", checked, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
